// ===== design/robust_variance_scaling_filter_defines.svh =====
// Assertion macros shared by the RTL of the robust variance scaling filter.
// No dependencies.
`ifndef ROBUST_VARIANCE_SCALING_FILTER_DEFINES_SVH
`define ROBUST_VARIANCE_SCALING_FILTER_DEFINES_SVH
// implication checked on every edge outside reset
`define RVSF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define RVSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/rvsf_pkg.sv =====
// Package for the robust variance scaling filter: types, constants, commands.
// No dependencies.
`default_nettype none
package rvsf_pkg;
  localparam int unsigned RetW   = 24;
  localparam int unsigned OutW   = 32;
  localparam int unsigned VarW   = 32;
  localparam logic [31:0] VarOne = 32'd65536;

  localparam logic [1:0] CfgAlpha = 2'd0;
  localparam logic [1:0] CfgBeta  = 2'd1;
  localparam logic [1:0] CfgCy1   = 2'd2;
  localparam logic [1:0] CfgClip  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_T1, ST_T2, ST_P, ST_ROOT, ST_SCALE, ST_NEXT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic do_sq;      // r^2, clip
    logic do_t1;      // a*cy1
    logic do_t2;      // (a*cy1)*m
    logic do_p;       // q*s, new variance
    logic root_start; // begin square root
    logic root_step;  // one root iteration
    logic do_scale;   // root*r, write variance
    logic out_load;   // saturate, move lane result into build register
    logic out_push;   // copy finished word to output register
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic root_done;
    logic last_lane;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/rvsf_datapath.sv =====
// Datapath of the robust variance scaling filter: lane variances, multipliers,
// square root unit, result register. Uses rvsf_pkg and the defines header.
`default_nettype none
`include "robust_variance_scaling_filter_defines.svh"
module rvsf_datapath #(
  parameter int unsigned NDIM = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rvsf_pkg::cmd_t           cmd,
  output rvsf_pkg::sts_t                sts,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_idx,
  input  wire logic [23:0]              cfg_data,
  input  wire logic [NDIM*24:0]         in_word,
  output logic [NDIM*32-1:0]            out_word
);
  localparam int unsigned LW = (NDIM > 1) ? $clog2(NDIM) : 1;

  logic [15:0] alpha_gain, beta_gain;
  logic [17:0] cy1;
  logic [23:0] clip;
  logic [31:0] lane_variance [NDIM];
  logic [NDIM*24-1:0] rets;
  logic               start;
  logic [LW-1:0]      lane;
  logic [NDIM*32-1:0] res;
  logic [NDIM*32-1:0] obuf;

  logic signed [23:0] r;
  logic [31:0] q;
  logic [23:0] m;
  logic [33:0] acy;
  logic [31:0] t;
  logic [31:0] qnew;
  logic [47:0] rem, acc, rbit;
  logic signed [56:0] prod;
  logic signed [40:0] scq;
  logic [31:0] sc;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= 16'd3277;
      beta_gain  <= 16'd58982;
      cy1        <= 18'd68983;
      clip       <= 24'd251753;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rvsf_pkg::CfgAlpha: alpha_gain <= cfg_data[15:0];
        rvsf_pkg::CfgBeta:  beta_gain  <= cfg_data[15:0];
        rvsf_pkg::CfgCy1:   cy1        <= cfg_data[17:0];
        rvsf_pkg::CfgClip:  clip       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign r = rets[lane*24 +: 24];
  assign q = start ? rvsf_pkg::VarOne : lane_variance[lane];
  assign sts.last_lane = (lane == LW'(NDIM - 1));
  assign sts.root_done = (rbit == 48'd0);
  assign out_word = obuf;

  logic [23:0] mag;
  logic [47:0] r2full;
  logic [31:0] s;
  logic [58:0] pq;
  logic signed [49:0] qn;
  logic [47:0] trial;
  assign mag = r[23] ? 24'(-r) : 24'(r);
  assign r2full = 48'(mag) * 48'(mag);
  assign s = t + 32'(beta_gain);
  assign pq = 59'(q) * 59'(s[26:0]);
  assign qn = $signed({7'b0, pq[58:16]}) + 50'sd65536
              - $signed(50'(alpha_gain)) - $signed(50'(beta_gain));
  assign trial = acc + rbit;
  assign scq = 41'(prod >>> 16);

  // saturate the scaled lane to the int32 range
  always_comb begin
    if (scq > 41'sh7FFFFFFF) sc = 32'h7FFF_FFFF;
    else if (scq < -41'sh80000000) sc = 32'h8000_0000;
    else sc = scq[31:0];
  end

  // lane sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      lane  <= '0;
      start <= 1'b0;
    end else if (cmd.load) begin
      rets  <= in_word[NDIM*24:1];
      start <= in_word[0];
      lane  <= '0;
    end else if (cmd.do_scale) begin
      if (sts.last_lane) begin
        start <= 1'b0;
        lane  <= '0;
      end else begin
        lane <= lane + LW'(1);
      end
    end
  end

  // variance recurrence and scaling, one lane at a time
  always_ff @(posedge clk) begin
    if (cmd.do_sq) m <= (r2full[46:16] < 31'(clip)) ? r2full[39:16] : clip;
    if (cmd.do_t1) acy <= 34'(alpha_gain) * 34'(cy1);
    if (cmd.do_t2) t <= 32'((64'(acy) * 64'(m)) >> 32);
    if (cmd.do_p) begin
      if (qn < 0) qnew <= '0;
      else if (qn > 50'sh0FFFFFFFF) qnew <= 32'hFFFF_FFFF;
      else qnew <= qn[31:0];
    end
    if (cmd.root_start) begin
      rem  <= {q, 16'd0};
      acc  <= '0;
      rbit <= 48'h4000_0000_0000;
    end else if (cmd.root_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + rbit;
      end else begin
        acc <= acc >> 1;
      end
      rbit <= rbit >> 2;
    end
    // acc holds the root once all iterations are done
    if (cmd.do_scale) prod <= $signed({25'd0, acc[31:0]}) * 57'(r);
  end

  // scale product is registered on do_scale and ready in the next cycle; out_load writes the lane
  logic [LW-1:0] plane;
  always_ff @(posedge clk) begin
    if (cmd.do_scale) plane <= lane;
    if (cmd.out_load) res[plane*32 +: 32] <= sc;
    if (cmd.out_push) obuf <= res;
  end

  // variance store; start forces 1.0 into q for every lane of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NDIM; i++) lane_variance[i] <= rvsf_pkg::VarOne;
    end else if (cmd.do_scale) begin
      lane_variance[lane] <= qnew;
    end
  end

  `RVSF_ASSERT_NEXT(a_root_shrinks, cmd.root_step && rbit != 48'd0, rbit == $past(rbit) >> 2)
  `RVSF_ASSERT_IMPL(a_no_load_midroot, cmd.load, !cmd.root_step)
  `RVSF_ASSERT_NEXT(a_lane_wraps, cmd.do_scale && sts.last_lane, lane == '0)
endmodule
`default_nettype wire

// ===== design/rvsf_ctrl.sv =====
// Controller of the robust variance scaling filter: sequences lanes and the
// root unit, runs the stream handshakes. Uses rvsf_pkg and the defines header.
`default_nettype none
`include "robust_variance_scaling_filter_defines.svh"
module rvsf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rvsf_pkg::cmd_t      cmd,
  input  wire rvsf_pkg::sts_t sts
);
  rvsf_pkg::state_t state, state_next;
  logic pend;              // last lane product awaiting saturation
  logic hold;              // finished word waits for the output register
  logic full;              // out_word holds an untaken word
  logic push;              // finished word moves to the output register
  logic lane_done_q;       // lane just scaled was the last one

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rvsf_pkg::ST_IDLE;
      pend  <= 1'b0;
      hold  <= 1'b0;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= cmd.do_scale && sts.last_lane;
      if (pend) hold <= 1'b1;
      else if (push) hold <= 1'b0;
      if (push) full <= 1'b1;
      else if (out_valid && out_ready) full <= 1'b0;
    end
  end

  assign push      = hold && (!full || out_ready);
  assign out_valid = full;
  assign in_ready  = (state == rvsf_pkg::ST_IDLE) && !pend && !hold;

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.out_push = push;
    unique case (state)
      rvsf_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = rvsf_pkg::ST_SQ;
        end
      end
      rvsf_pkg::ST_SQ: begin
        cmd.do_sq = 1'b1;
        cmd.do_t1 = 1'b1;
        cmd.root_start = 1'b1;
        state_next = rvsf_pkg::ST_T2;
      end
      rvsf_pkg::ST_T2: begin
        cmd.do_t2 = 1'b1;
        cmd.root_step = 1'b1;
        state_next = rvsf_pkg::ST_P;
      end
      rvsf_pkg::ST_P: begin
        cmd.do_p = 1'b1;
        cmd.root_step = 1'b1;
        state_next = rvsf_pkg::ST_ROOT;
      end
      rvsf_pkg::ST_ROOT: begin
        if (sts.root_done) state_next = rvsf_pkg::ST_SCALE;
        else cmd.root_step = 1'b1;
      end
      rvsf_pkg::ST_SCALE: begin
        cmd.do_scale = 1'b1;
        state_next = rvsf_pkg::ST_NEXT;
      end
      rvsf_pkg::ST_NEXT: begin
        cmd.out_load = 1'b1;
        state_next = (lane_done_q) ? rvsf_pkg::ST_IDLE : rvsf_pkg::ST_SQ;
      end
      default: state_next = rvsf_pkg::ST_IDLE;
    endcase
  end

  // remembers whether the lane just scaled was the last one
  always_ff @(posedge clk) begin
    if (cmd.do_scale) lane_done_q <= sts.last_lane;
  end

  `RVSF_ASSERT_IMPL(a_load_idle, cmd.load, state == rvsf_pkg::ST_IDLE)
  `RVSF_ASSERT_IMPL(a_no_accept_hold, in_valid && in_ready, !hold)
  `RVSF_ASSERT_NEXT(a_pend_holds, pend, hold)
endmodule
`default_nettype wire

// ===== design/robust_variance_scaling_filter.sv =====
// Robust variance scaling filter: one row of NDIM Q8.16 returns in, NDIM
// Q16.16 variance-scaled returns out, per-lane variance recurrence. Each lane
// takes the square and gain product, 24 iterations of the shared bit-pair
// square root unit (two overlap the multiply steps) and a check that it has
// finished, then scale and saturate. A new row is accepted only after the
// previous row's word has moved to the output register, where it waits
// while the next row is processed. Uses rvsf_pkg.
`default_nettype none
module robust_variance_scaling_filter #(
  parameter int unsigned NDIM = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_idx,
  input  wire logic [23:0]           cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [NDIM*24-1:0]    s_tdata,  // return_0 .. return_N-1
  input  wire logic                  s_tuser,  // start_series
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [NDIM*32-1:0]         m_tdata   // scaled_0 .. scaled_N-1
);
  rvsf_pkg::cmd_t cmd;
  rvsf_pkg::sts_t sts;

  rvsf_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd(cmd), .sts(sts)
  );

  rvsf_datapath #(.NDIM(NDIM)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_word({s_tdata, s_tuser}), .out_word(m_tdata)
  );
endmodule
`default_nettype wire

// ===== bench/robust_variance_scaling_filter_tb.sv =====
// Testbench for the robust variance scaling filter: directed and random rows
// of returns are pushed through the stream input and checked against a
// per-lane predictor. Depends on rvsf_pkg and robust_variance_scaling_filter.
`timescale 1ns / 100ps
`default_nettype none
module robust_variance_scaling_filter_tb;
  localparam int unsigned NLANE = 4;
  localparam int unsigned RAND_ROWS = 1800;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                  start;
    logic [NLANE*24-1:0]   rets;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = rvsf_pkg::CfgAlpha;
  logic [23:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [NLANE*24-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [NLANE*32-1:0] m_tdata;

  // predictor copy of configuration and state
  logic [15:0] gain_a, gain_b;
  logic [17:0] cy1;
  logic [23:0] clip;
  logic [31:0] lane_var [NLANE];

  row_t pending_rows[$];
  logic [NLANE*32-1:0] expected_words[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  robust_variance_scaling_filter #(.NDIM(NLANE)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),  // return_0 .. return_3
    .s_tuser(s_tuser),  // start_series
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)   // scaled_0 .. scaled_3
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // one row through the variance recurrence; returns scaled word
  function automatic logic [NLANE*32-1:0] scale_row(row_t row);
    logic [NLANE*32-1:0] word;
    longint r, mag, r2, m, t, s, p, qn, root, sc;
    word = '0;
    if (row.start) for (int i = 0; i < NLANE; i++) lane_var[i] = rvsf_pkg::VarOne;
    for (int i = 0; i < NLANE; i++) begin
      r = longint'(signed'(row.rets[i*24 +: 24]));
      mag = r < 0 ? -r : r;
      r2 = (mag * mag) >>> 16;
      m = r2 < longint'(clip) ? r2 : longint'(clip);
      t = longint'((64'(gain_a) * 64'(cy1) * 64'(m)) >> 32);
      s = t + gain_b;
      p = longint'((64'(lane_var[i]) * 64'(s)) >> 16);
      qn = p + 65536 - gain_a - gain_b;
      root = longint'(int_sqrt(64'(lane_var[i]) << 16));
      sc = (root * r) >>> 16;
      if (sc > 64'sd2147483647) sc = 64'sd2147483647;
      if (sc < -64'sd2147483648) sc = -64'sd2147483648;
      word[i*32 +: 32] = sc[31:0];
      if (qn < 0) qn = 0;
      if (qn > 64'sh FFFFFFFF) qn = 64'shFFFFFFFF;
      lane_var[i] = qn[31:0];
    end
    return word;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rvsf_pkg::CfgAlpha: gain_a = val[15:0];
      rvsf_pkg::CfgBeta:  gain_b = val[15:0];
      rvsf_pkg::CfgCy1:   cy1 = val[17:0];
      default:            clip = val;
    endcase
  endtask

  function automatic logic [23:0] rand_return();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 2 * 65536)) - 24'd65536;
      3: return 24'($urandom_range(0, 8 * 65536)) - 24'd262144;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic queue_row(logic st, logic [23:0] r0, logic [23:0] r1,
                           logic [23:0] r2, logic [23:0] r3);
    row_t row;
    row.start = st;
    row.rets = {r3, r2, r1, r0};
    pending_rows.push_back(row);
    expected_words.push_back(scale_row(row));
  endtask

  task automatic queue_random(int n);
    for (int k = 0; k < n; k++)
      queue_row($urandom_range(0, 19) == 0, rand_return(), rand_return(),
                rand_return(), rand_return());
  endtask

  task automatic drain();
    while (pending_rows.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // driver: bursts and gaps; the front of the queue is the next word to offer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) void'(pending_rows.pop_front());
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          row_t nxt;
          nxt = pending_rows[0];
          s_tvalid <= 1'b1;
          s_tdata <= nxt.rets;
          s_tuser <= nxt.start;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 120);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern and monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      m_tready <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[31:0], '0);
        end else begin
          logic [NLANE*32-1:0] want;
          want = expected_words.pop_front();
          for (int i = 0; i < NLANE; i++)
            if (m_tdata[i*32 +: 32] !== want[i*32 +: 32])
              report_mismatch($sformatf("scaled_%0d", i), m_tdata[i*32 +: 32],
                              want[i*32 +: 32]);
        end
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    gain_a = 16'd3277; gain_b = 16'd58982; cy1 = 18'd68983; clip = 24'd251753;
    for (int i = 0; i < NLANE; i++) lane_var[i] = rvsf_pkg::VarOne;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, start flag, zero, ones
    queue_row(1'b0, 24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF);
    queue_row(1'b0, 24'h010000, 24'hFF0000, 24'h000001, 24'h7FFFFF);
    queue_row(1'b1, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h000000);
    for (int k = 0; k < 8; k++)
      queue_row(1'b0, 24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000);
    drain();
    // variance driven toward zero: a + b above 1.0
    write_reg(rvsf_pkg::CfgAlpha, 24'hFFFF);
    write_reg(rvsf_pkg::CfgBeta, 24'hFFFF);
    write_reg(rvsf_pkg::CfgCy1, 24'h0);
    write_reg(rvsf_pkg::CfgClip, 24'h0);
    queue_row(1'b1, 24'h7FFFFF, 24'h800000, 24'h010000, 24'hFFFFFF);
    for (int k = 0; k < 4; k++)
      queue_row(1'b0, 24'h123456, 24'hEDCBA9, 24'h7FFFFF, 24'h800000);
    drain();
    // maximal growth: huge news weight, clip open
    write_reg(rvsf_pkg::CfgAlpha, 24'hFFFF);
    write_reg(rvsf_pkg::CfgBeta, 24'h0);
    write_reg(rvsf_pkg::CfgCy1, 24'h3FFFF);
    write_reg(rvsf_pkg::CfgClip, 24'hFFFFFF);
    queue_row(1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    for (int k = 0; k < 6; k++)
      queue_row(1'b0, 24'h7FFFFF, 24'h800000, 24'h100000, 24'hF00000);
    queue_random(200);
    drain();
    // random settings in phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rvsf_pkg::CfgAlpha, 24'($urandom_range(0, 65535)));
      write_reg(rvsf_pkg::CfgBeta, 24'($urandom_range(0, 65535)));
      write_reg(rvsf_pkg::CfgCy1, 24'($urandom_range(0, 262143)));
      write_reg(rvsf_pkg::CfgClip, 24'($urandom));
      queue_row(1'b1, rand_return(), rand_return(), rand_return(), rand_return());
      queue_random(RAND_ROWS / 9);
      drain();
    end
    // back to typical values
    write_reg(rvsf_pkg::CfgAlpha, 24'd3277);
    write_reg(rvsf_pkg::CfgBeta, 24'd58982);
    write_reg(rvsf_pkg::CfgCy1, 24'd68983);
    write_reg(rvsf_pkg::CfgClip, 24'd251753);
    queue_random(RAND_ROWS / 9);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
